[rtl/text_redaction_filter_assert.svh]
// Assertion macros used by the checker file.
`ifndef TEXT_REDACTION_FILTER_ASSERT_SVH
`define TEXT_REDACTION_FILTER_ASSERT_SVH
// Implication that must hold at every clock edge outside reset.
`define TRF_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// Implication checked in the cycle after the antecedent.
`define TRF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

[rtl/trf_pkg.sv]
// ----------------------------------------------------------------------------
// Text redaction filter package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package trf_pkg;
   localparam int MaxPatternDefault = 32;
   localparam logic [15:0] CapacityReset = 16'd256;
   localparam logic [15:0] TagLen = 16'd6;

   typedef enum logic [1:0] {
      OP_HOST  = 2'd0,
      OP_USER  = 2'd1,
      OP_MSG   = 2'd2,
      OP_CLEAR = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_HOST = 2'd1,
      KIND_USER = 2'd2,
      KIND_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;     // take the accepted input word
      logic decide;   // decide the head position
      logic finish;   // emit end marker and clear message state
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_decide; // window must be resolved
      logic flushing;    // end of message pending
   } status_type;

   function automatic logic [7:0] sanitize(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == 8'h0d || c == 8'h0a || c == 8'h09) r = 8'h20;
      else if (c < 8'h20 || c > 8'h7e) r = 8'h3f;
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/trf_datapath.sv]
// ----------------------------------------------------------------------------
// Text redaction filter datapath
// Pattern stores, look-ahead window, match comparators and output counter.
// ----------------------------------------------------------------------------
`default_nettype none
module trf_datapath
   import trf_pkg::*;
#(
   parameter int MAX_PATTERN = MaxPatternDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [15:0] capacity,
   input  wire logic [1:0]  in_op,
   input  wire logic [7:0]  in_byte,
   input  wire logic        in_eom,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic             res_valid,
   output logic [1:0]       res_kind,
   output logic [7:0]       res_char,
   output logic             res_trunc,
   output logic             res_final
);
   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam logic [CW-1:0] MaxCnt = CW'(MAX_PATTERN);

   logic [7:0] host_pat_ff [MAX_PATTERN];
   logic [7:0] user_pat_ff [MAX_PATTERN];
   logic [7:0] win_ff [MAX_PATTERN];
   logic [CW-1:0] host_len_ff, user_len_ff, win_cnt_ff;
   logic host_long_ff, user_long_ff, stopped_ff, eom_ff;
   logic [15:0] written_ff;

   logic host_hit, user_hit, use_host;
   logic [CW-1:0] drop_n;
   logic [16:0] w1, w6;

   always_comb begin
      host_hit = (host_len_ff != '0) && !host_long_ff && (host_len_ff <= win_cnt_ff);
      user_hit = (user_len_ff != '0) && !user_long_ff && (user_len_ff <= win_cnt_ff);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CW'(i) < host_len_ff && win_ff[i] != host_pat_ff[i]) host_hit = 1'b0;
         if (CW'(i) < user_len_ff && win_ff[i] != user_pat_ff[i]) user_hit = 1'b0;
      end
      use_host = host_hit && (!user_hit || host_len_ff >= user_len_ff);
      drop_n = (host_hit || user_hit) ? (use_host ? host_len_ff : user_len_ff)
                                      : CW'(1);
      w1 = {1'b0, written_ff} + 17'd1;
      w6 = {1'b0, written_ff} + {1'b0, TagLen};
   end

   assign status.need_decide = (win_cnt_ff != '0) &&
                               (eom_ff || win_cnt_ff >= MaxCnt);
   assign status.flushing = eom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid <= 1'b0;
         host_len_ff <= '0; user_len_ff <= '0;
         host_long_ff <= 1'b0; user_long_ff <= 1'b0;
         win_cnt_ff <= '0; written_ff <= '0;
         stopped_ff <= 1'b0; eom_ff <= 1'b0;
      end else if (cmd.load) begin
         res_valid <= 1'b0;
         unique case (opcode_type'(in_op))
            OP_HOST: if (host_len_ff < MaxCnt) begin
               host_pat_ff[host_len_ff[IW-1:0]] <= in_byte;
               host_len_ff <= host_len_ff + CW'(1);
            end else host_long_ff <= 1'b1;
            OP_USER: if (user_len_ff < MaxCnt) begin
               user_pat_ff[user_len_ff[IW-1:0]] <= in_byte;
               user_len_ff <= user_len_ff + CW'(1);
            end else user_long_ff <= 1'b1;
            OP_CLEAR: begin
               host_len_ff <= '0; user_len_ff <= '0;
               host_long_ff <= 1'b0; user_long_ff <= 1'b0;
            end
            OP_MSG: begin
               if (!stopped_ff && win_cnt_ff < MaxCnt) begin
                  win_ff[win_cnt_ff[IW-1:0]] <= in_byte;
                  win_cnt_ff <= win_cnt_ff + CW'(1);
               end
               eom_ff <= in_eom;
            end
            default: ;
         endcase
      end else if (cmd.decide) begin
         if (stopped_ff) begin
            res_valid <= 1'b0;
            win_cnt_ff <= '0;
         end else if (w1 >= {1'b0, capacity} ||
                      ((host_hit || user_hit) && w6 >= {1'b0, capacity})) begin
            res_valid <= 1'b0;
            stopped_ff <= 1'b1;
            win_cnt_ff <= '0;
         end else begin
            res_valid <= 1'b1;
            res_trunc <= 1'b0;
            res_final <= 1'b0;
            if (host_hit || user_hit) begin
               res_kind <= use_host ? KIND_HOST : KIND_USER;
               res_char <= 8'h00;
               written_ff <= w6[15:0];
            end else begin
               res_kind <= KIND_CHAR;
               res_char <= sanitize(win_ff[0]);
               written_ff <= w1[15:0];
            end
            // Shift the window down by the consumed length.
            for (int i = 0; i < MAX_PATTERN; i++)
               if (i + int'(drop_n) < MAX_PATTERN)
                  win_ff[i] <= win_ff[i + int'(drop_n)];
            win_cnt_ff <= (drop_n >= win_cnt_ff) ? '0 : win_cnt_ff - drop_n;
         end
      end else if (cmd.finish) begin
         res_valid <= 1'b1;
         res_kind <= KIND_END;
         res_char <= 8'h00;
         res_trunc <= stopped_ff;
         res_final <= 1'b1;
         win_cnt_ff <= '0; written_ff <= '0;
         stopped_ff <= 1'b0; eom_ff <= 1'b0;
      end else begin
         res_valid <= 1'b0;
      end
   end
endmodule
`default_nettype wire

[rtl/trf_ctrl.sv]
// ----------------------------------------------------------------------------
// Text redaction filter controller
// Sequences input loading, head decisions and output delivery.
// ----------------------------------------------------------------------------
`default_nettype none
module trf_ctrl
   import trf_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_fire,
   input  wire logic  out_busy,
   input  wire status_type status,
   output cmd_type    cmd,
   output logic       in_ready
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (in_fire) state_in = ST_DECIDE;
         ST_DECIDE: if (!out_busy) state_in = ST_OUT;
         ST_OUT: begin
            // Pass through this state so the decision result reaches the output slot.
            if (status.need_decide || status.flushing) state_in = ST_DECIDE;
            else state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = !out_busy;
            cmd.load = in_fire;
         end
         ST_DECIDE: if (!out_busy) begin
            cmd.decide = status.need_decide;
            cmd.finish = !status.need_decide && status.flushing;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[rtl/text_redaction_filter.sv]
// A result word passes through the datapath result register, then the output
// register. A new input word is taken only in the idle state, after each window
// decision and emitted word has passed the shared match unit; a busy output stalls decisions.
// End of message flushes up to MAX_PATTERN positions, then emits the end marker.
// Reset (synchronous, active high) clears lengths, window, counters and
// sets the capacity to 256.
`default_nettype none
module text_redaction_filter
   import trf_pkg::*;
#(
   parameter int MAX_PATTERN = MaxPatternDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // opcode[1:0], data_byte[9:2], zeros
   input  wire logic        req_tlast,  // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // token_kind[1:0], out_char[9:2], truncated[10]
   output logic             rsp_tlast   // final_res
);
   logic [15:0] cap_ff;
   cmd_type cmd;
   status_type status;
   logic res_valid, res_trunc, res_final, out_ff_valid;
   logic [1:0] res_kind;
   logic [7:0] res_char;
   logic in_fire;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= CapacityReset;
      else if (csr_we) cap_ff <= csr_wdata;
   end

   assign in_fire = req_tvalid && req_tready;

   trf_ctrl u_ctrl (
      .clock, .reset, .in_fire,
      .out_busy(out_ff_valid && !rsp_tready),
      .status, .cmd, .in_ready(req_tready)
   );

   trf_datapath #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
      .clock, .reset, .capacity(cap_ff),
      .in_op(req_tdata[1:0]), .in_byte(req_tdata[9:2]), .in_eom(req_tlast),
      .cmd, .status, .res_valid, .res_kind, .res_char, .res_trunc, .res_final
   );

   // Output register; a new result only arrives when the slot is free.
   always_ff @(posedge clock) begin
      if (reset) out_ff_valid <= 1'b0;
      else if (res_valid) out_ff_valid <= 1'b1;
      else if (rsp_tready) out_ff_valid <= 1'b0;
      if (res_valid) begin
         rsp_tdata <= {5'd0, res_trunc, res_char, res_kind};
         rsp_tlast <= res_final;
      end
   end
   assign rsp_tvalid = out_ff_valid;
endmodule
`default_nettype wire

[rtl/trf_checker.sv]
// ----------------------------------------------------------------------------
// Text redaction filter port checker
// Watches the top-level ports for output consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_redaction_filter_assert.svh"
module trf_checker
   import trf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   logic stall, is_end, is_tag, not_last;

   assign stall = rsp_tvalid && !rsp_tready;
   assign is_end = rsp_tdata[1:0] == KIND_END;
   assign is_tag = rsp_tdata[1:0] != KIND_CHAR;
   assign not_last = rsp_tvalid && !rsp_tlast;

   `TRF_ASSERT_NEXT(a_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata), "word changed")
   `TRF_ASSERT_IMPL(a_last_kind, clock, reset, rsp_tvalid, rsp_tlast == is_end, "last mismatch")
   `TRF_ASSERT_IMPL(a_tag_char, clock, reset, rsp_tvalid && is_tag, rsp_tdata[9:2] == 8'd0, "tag with char")
   `TRF_ASSERT_IMPL(a_trunc, clock, reset, not_last, !rsp_tdata[10], "truncated off marker")
endmodule
bind text_redaction_filter trf_checker u_chk (.*);
`default_nettype wire
